// File: sv/morse_led_keyer_unit_macros.svh
// Assertion macros for the Morse LED keyer modules, used by the interval queue.
`ifndef MORSE_LED_KEYER_UNIT_MACROS_SVH
`define MORSE_LED_KEYER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define MLK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define MLK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/mlk_pkg.sv
// Types, constants and the Morse lookup table of the LED keyer.
`default_nettype none

package mlk_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int TICKS_W = 16;
    localparam int DUR_W   = 19;
    localparam int UNITS_W = 3;
    localparam int LEN_W   = 3;
    localparam int PAT_W   = 5;
    localparam int IDX_W   = 6;

    // Element queue geometry
    localparam int QDEPTH = 16;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Reset value of the unit length
    localparam logic [TICKS_W-1:0] UNIT_TICKS_RST = 16'd500;

    // Interval lengths in units
    localparam logic [UNITS_W-1:0] UNITS_DOT       = 3'd1;
    localparam logic [UNITS_W-1:0] UNITS_DASH      = 3'd3;
    localparam logic [UNITS_W-1:0] UNITS_ELEM_GAP  = 3'd1;
    localparam logic [UNITS_W-1:0] UNITS_CHAR_GAP  = 3'd3;
    localparam logic [UNITS_W-1:0] UNITS_WORD_GAP  = 3'd7;

    // ASCII landmarks
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CASE_GAP   = CH_LOWER_A - CH_UPPER_A;
    localparam int                NUM_LETTERS = 26;
    localparam int                NUM_CODES   = 36;

    // Element count per symbol, letters A-Z then digits 0-9
    localparam logic [LEN_W-1:0] CODE_LEN [NUM_CODES] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    // Element pattern per symbol, first element in bit 0, 1 = dash
    localparam logic [PAT_W-1:0] CODE_PAT [NUM_CODES] = '{
        5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04, 5'h03, 5'h00, 5'h00, 5'h0E,
        5'h05, 5'h02, 5'h03, 5'h01, 5'h07, 5'h06, 5'h0B, 5'h02, 5'h00, 5'h01,
        5'h04, 5'h08, 5'h06, 5'h09, 5'h0D, 5'h03,
        5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F
    };

    // Looked-up symbol
    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } t_code;

    // One queued interval, before scaling by the unit length
    typedef struct packed {
        logic               led_on;
        logic [UNITS_W-1:0] units;
        logic               last_of_char;
        logic               message_done;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One finished result
    typedef struct packed {
        logic             led_on;
        logic [DUR_W-1:0] duration_ticks;
        logic             last_of_char;
        logic             message_done;
    } t_result;

    // Queue write request from the element generator
    typedef struct packed {
        logic   we;
        t_entry data;
    } t_wr_req;

    // Queue status back to the element generator
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Fold case and look the character up in the Morse table
    function automatic t_code mlk_lookup(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] up;
        logic [CHAR_W-1:0] off;
        t_code             res;
        up  = ch;
        off = '0;
        res = '0;
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            up = ch - CASE_GAP;
        end
        if (up >= CH_ZERO && up <= CH_NINE) begin
            off     = up - CH_ZERO + CHAR_W'(NUM_LETTERS);
            res.hit = 1'b1;
        end else if (up >= CH_UPPER_A && up <= CH_UPPER_Z) begin
            off     = up - CH_UPPER_A;
            res.hit = 1'b1;
        end
        if (res.hit) begin
            res.len = CODE_LEN[off[IDX_W-1:0]];
            res.pat = CODE_PAT[off[IDX_W-1:0]];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/mlk_stream_if.sv
// Valid/ready channel interfaces for characters in and intervals out.
`default_nettype none

interface mlk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_message;

    modport source (output valid, output char_code, output end_of_message, input ready);
    modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

interface mlk_out_if;
    logic        valid;
    logic        ready;
    logic        led_on;
    logic [18:0] duration_ticks;
    logic        last_of_char;
    logic        message_done;

    modport source (output valid, output led_on, output duration_ticks,
                    output last_of_char, output message_done, input ready);
    modport sink   (input valid, input led_on, input duration_ticks,
                    input last_of_char, input message_done, output ready);
endinterface

`default_nettype wire

// File: sv/mlk_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mlk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/mlk_elem_gen.sv
// Element generator: turns one character into queued on/off intervals.
`default_nettype none

module mlk_elem_gen (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    mlk_in_if.sink                  i_in,
    input  wire mlk_pkg::t_q_status i_q_stat,
    output mlk_pkg::t_wr_req        o_wr
);
    import mlk_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ON   = 3'b010,
        S_OFF  = 3'b100
    } t_gen_state;

    t_gen_state       r_state, n_state;
    logic [PAT_W-1:0] r_pat,   n_pat;
    logic [LEN_W-1:0] r_left,  n_left;
    logic             r_gap,   n_gap;
    logic             r_eom,   n_eom;
    t_code            w_code;

    assign w_code     = mlk_lookup(i_in.char_code);
    assign i_in.ready = (r_state == S_IDLE);

    // Sequence the elements, one queue write per cycle while the queue is not full
    always_comb begin
        logic last_el;
        last_el   = r_gap || (r_left == LEN_W'(1));
        n_state   = r_state;
        n_pat     = r_pat;
        n_left    = r_left;
        n_gap     = r_gap;
        n_eom     = r_eom;
        o_wr      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_pat   = w_code.pat;
                    n_left  = w_code.len;
                    n_gap   = !w_code.hit;
                    n_eom   = i_in.end_of_message;
                    n_state = w_code.hit ? S_ON : S_OFF;
                end
            end
            S_ON: begin
                if (!i_q_stat.full) begin
                    o_wr.we                = 1'b1;
                    o_wr.data.led_on       = 1'b1;
                    o_wr.data.units        = r_pat[0] ? UNITS_DASH : UNITS_DOT;
                    o_wr.data.last_of_char = 1'b0;
                    o_wr.data.message_done = 1'b0;
                    n_state                = S_OFF;
                end
            end
            S_OFF: begin
                if (!i_q_stat.full) begin
                    o_wr.we                = 1'b1;
                    o_wr.data.led_on       = 1'b0;
                    o_wr.data.units        = r_gap   ? UNITS_WORD_GAP :
                                             last_el ? UNITS_CHAR_GAP : UNITS_ELEM_GAP;
                    o_wr.data.last_of_char = last_el;
                    o_wr.data.message_done = last_el && r_eom;
                    n_pat                  = r_pat >> 1;
                    n_left                 = r_left - LEN_W'(1);
                    n_state                = last_el ? S_IDLE : S_ON;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Character payload
    always_ff @(posedge i_clk) begin
        r_pat  <= n_pat;
        r_left <= n_left;
        r_gap  <= n_gap;
        r_eom  <= n_eom;
    end

endmodule

`default_nettype wire

// File: sv/mlk_elem_queue.sv
// Interval queue in RAM, unit scaling and registered output with skid stage.
`default_nettype none
`include "morse_led_keyer_unit_macros.svh"

module mlk_elem_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [mlk_pkg::TICKS_W-1:0] i_cfg_wdata,
    input  wire mlk_pkg::t_wr_req            i_wr,
    output mlk_pkg::t_q_status               o_q_stat,
    mlk_out_if.source                        o_out
);
    import mlk_pkg::*;

    logic [TICKS_W-1:0] r_unit_ticks;
    logic [QAW-1:0]     r_wr_ptr;
    logic [QAW-1:0]     r_rd_ptr;
    logic [QCW-1:0]     r_count, n_count;
    logic               r_pend;
    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    t_result            r_out, n_out;
    t_result            r_skid, n_skid;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry             w_entry;
    t_result            w_scaled;
    logic               w_pop;
    logic               w_rd_issue;
    logic [1:0]         w_occ;

    // Queue storage
    mlk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QDEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_wr.data),
        .i_re    (w_rd_issue),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rdata)
    );

    assign o_q_stat.full  = (r_count == QCW'(QDEPTH));
    assign o_q_stat.empty = (r_count == '0);

    // Issue a read only when the output side has a free slot for it
    assign w_pop      = r_out_valid && o_out.ready;
    assign w_occ      = {1'b0, r_out_valid} + {1'b0, r_skid_valid} + {1'b0, r_pend};
    assign w_rd_issue = !o_q_stat.empty && ((w_occ - {1'b0, w_pop}) < 2'd2);

    assign n_count = r_count + QCW'(i_wr.we) - QCW'(w_rd_issue);

    // Scale the returning entry by the unit length
    assign w_entry                 = t_entry'(w_rdata);
    assign w_scaled.led_on         = w_entry.led_on;
    assign w_scaled.duration_ticks = DUR_W'(w_entry.units) * DUR_W'(r_unit_ticks);
    assign w_scaled.last_of_char   = w_entry.last_of_char;
    assign w_scaled.message_done   = w_entry.message_done;

    // Move data through output and skid registers
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = w_scaled;
                n_skid_valid = r_pend;
            end else begin
                n_out        = w_scaled;
                n_out_valid  = r_pend;
            end
        end else if (r_pend) begin
            n_skid       = w_scaled;
            n_skid_valid = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= UNIT_TICKS_RST;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_unit_ticks <= i_cfg_wdata;
            end
            if (i_wr.we) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (w_rd_issue) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_count      <= n_count;
            r_pend       <= w_rd_issue;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.led_on         = r_out.led_on;
    assign o_out.duration_ticks = r_out.duration_ticks;
    assign o_out.last_of_char   = r_out.last_of_char;
    assign o_out.message_done   = r_out.message_done;

    `MLK_ASSERT_NOW(a_no_write_when_full, i_wr.we, !o_q_stat.full, "queue written while full")
    `MLK_ASSERT_NOW(a_no_rw_collision, i_wr.we && w_rd_issue, r_wr_ptr != r_rd_ptr, "read and write hit one entry")
    `MLK_ASSERT_NOW(a_skid_no_overrun, r_pend && r_skid_valid, w_pop, "returning read with no free slot")
    `MLK_ASSERT_NEXT(a_count_tracks_ptrs, i_wr.we && !w_rd_issue, !o_q_stat.empty, "queue count lost a write")

endmodule

`default_nettype wire

// File: sv/morse_led_keyer_unit.sv
// Top level of the Morse LED keyer.
`default_nettype none

// Morse LED keyer. Each character transaction on i_in is folded to upper
// case and looked up in the International Morse table (A-Z, 0-9); every
// dot or dash yields an LED-on interval of 1 or 3 units and an LED-off
// interval of 1 unit, or 3 units after the last element, while any other
// code yields a single 7-unit off interval. Intervals leave on o_out in
// time order, one transaction per interval, with durations in ticks
// (units times unit_ticks, written through i_cfg_we/i_cfg_wdata, reset
// value 500, to be changed only while the block is idle). While a character
// is expanded the input is held not ready and the element generator writes
// one interval per cycle, unless the queue is full, into a 16-entry RAM
// queue; each entry passes the RAM read register, is scaled and enters the
// output (or skid) register, and results then leave at up to one per cycle
// while o_out is ready, as the next character is already being accepted.
module morse_led_keyer_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mlk_in_if.sink                           i_in,
    mlk_out_if.source                        o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [mlk_pkg::TICKS_W-1:0] i_cfg_wdata
);
    import mlk_pkg::*;

    t_wr_req   w_wr;
    t_q_status w_q_stat;

    // Expand characters into intervals
    mlk_elem_gen u_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_wr     (w_wr)
    );

    // Queue, scale and deliver intervals
    mlk_elem_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_wr        (w_wr),
        .o_q_stat    (w_q_stat),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// File: bench/morse_led_keyer_unit_test.sv
// Self-checking testbench for the Morse LED keyer: directed and random character traffic.
`timescale 1ns / 1ps

module morse_led_keyer_unit_test;
    import mlk_pkg::*;

    // ASCII landmarks for the keying predictor
    localparam logic [7:0] ASC_LOW_A = 8'h61;
    localparam logic [7:0] ASC_LOW_Z = 8'h7A;
    localparam logic [7:0] ASC_UP_A  = 8'h41;
    localparam logic [7:0] ASC_UP_Z  = 8'h5A;
    localparam logic [7:0] ASC_ZERO  = 8'h30;
    localparam logic [7:0] ASC_NINE  = 8'h39;
    localparam logic [7:0] ASC_SPACE = 8'h20;
    localparam logic [7:0] ASC_DASH  = 8'h2D;
    localparam logic [7:0] CASE_DIFF = ASC_LOW_A - ASC_UP_A;

    // Interval lengths in Morse units
    localparam int DOT_UNITS  = 1;
    localparam int DASH_UNITS = 3;
    localparam int ELEM_GAP   = 1;
    localparam int CHAR_GAP   = 3;
    localparam int WORD_GAP   = 7;

    // Cycles without any accepted transaction while work is outstanding
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_we;
    logic [TICKS_W-1:0]  cfg_wdata;

    mlk_in_if  char_ch ();
    mlk_out_if interval_ch ();

    morse_led_keyer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (char_ch),
        .o_out       (interval_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Predictor state and scoreboard
    logic [TICKS_W-1:0] unit_len;
    t_result            intervals_due[$];
    int                 fail_count;
    int                 chars_sent;
    int                 intervals_checked;
    int                 settings_used;
    bit                 no_idle;
    int                 stall_cycles;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Dot/dash pattern per symbol, letters A-Z then digits 0-9
    function automatic string morse_pattern(input int sym);
        case (sym)
            0:  return ".-";
            1:  return "-...";
            2:  return "-.-.";
            3:  return "-..";
            4:  return ".";
            5:  return "..-.";
            6:  return "--.";
            7:  return "....";
            8:  return "..";
            9:  return ".---";
            10: return "-.-";
            11: return ".-..";
            12: return "--";
            13: return "-.";
            14: return "---";
            15: return ".--.";
            16: return "--.-";
            17: return ".-.";
            18: return "...";
            19: return "-";
            20: return "..-";
            21: return "...-";
            22: return ".--";
            23: return "-..-";
            24: return "-.--";
            25: return "--..";
            26: return "-----";
            27: return ".----";
            28: return "..---";
            29: return "...--";
            30: return "....-";
            31: return ".....";
            32: return "-....";
            33: return "--...";
            34: return "---..";
            35: return "----.";
            default: return "";
        endcase
    endfunction

    function automatic t_result make_interval(input logic on, input int units,
                                              input logic last, input logic done);
        t_result r;
        r.led_on         = on;
        r.duration_ticks = DUR_W'(units * int'(unit_len));
        r.last_of_char   = last;
        r.message_done   = done;
        return r;
    endfunction

    // Queue the intervals that keying one character produces
    task automatic predict_intervals(input logic [7:0] ch, input logic eom);
        logic [7:0] up;
        int         sym;
        string      pat;
        bit         final_elem;
        up  = ch;
        sym = -1;
        if (ch >= ASC_LOW_A && ch <= ASC_LOW_Z)
            up = ch - CASE_DIFF;
        if (up >= ASC_ZERO && up <= ASC_NINE)
            sym = int'(up - ASC_ZERO) + 26;
        else if (up >= ASC_UP_A && up <= ASC_UP_Z)
            sym = int'(up - ASC_UP_A);
        if (sym < 0) begin
            intervals_due.push_back(make_interval(1'b0, WORD_GAP, 1'b1, eom));
        end else begin
            pat = morse_pattern(sym);
            for (int i = 0; i < pat.len(); i++) begin
                final_elem = (i == pat.len() - 1);
                intervals_due.push_back(make_interval(1'b1,
                    (pat[i] == ASC_DASH) ? DASH_UNITS : DOT_UNITS, 1'b0, 1'b0));
                intervals_due.push_back(make_interval(1'b0,
                    final_elem ? CHAR_GAP : ELEM_GAP, final_elem, final_elem & eom));
            end
        end
    endtask

    function automatic bit take_break();
        return !no_idle && ($urandom_range(99) < 6);
    endfunction

    // Send one character transaction; entered and left at a falling edge
    task automatic send_char(input logic [7:0] ch, input logic eom);
        while (take_break()) begin
            char_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        char_ch.valid          <= 1'b1;
        char_ch.char_code      <= ch;
        char_ch.end_of_message <= eom;
        do
            @(posedge i_clk);
        while (char_ch.ready !== 1'b1);
        predict_intervals(ch, eom);
        chars_sent++;
        @(negedge i_clk);
    endtask

    // Hold until every expected interval has come out, then settle
    task automatic wait_drained();
        char_ch.valid <= 1'b0;
        while (intervals_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write the unit length while the keyer is idle
    task automatic set_unit_ticks(input logic [TICKS_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        unit_len  = v;
        settings_used++;
    endtask

    // Random traffic: mostly well-formed messages, some noise bytes
    task automatic send_messages(input int n_items);
        int         sent;
        int         len;
        int         pick;
        bit         noise;
        logic [7:0] ch;
        sent = 0;
        while (sent < n_items) begin
            len   = $urandom_range(8, 1);
            noise = ($urandom_range(99) < 12);
            for (int k = 0; k < len && sent < n_items; k++) begin
                if (noise) begin
                    send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 45)
                        ch = ASC_UP_A + 8'($urandom_range(25));
                    else if (pick < 80)
                        ch = ASC_LOW_A + 8'($urandom_range(25));
                    else if (pick < 92)
                        ch = ASC_ZERO + 8'($urandom_range(9));
                    else
                        ch = ASC_SPACE;
                    send_char(ch, k == len - 1);
                end
                sent++;
            end
        end
    endtask

    // Reset value of the unit length must be in effect
    task automatic test_reset_length();
        send_char("E", 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    // Longest unit with the longest symbols and codes at the edges of the table
    task automatic test_long_unit();
        set_unit_ticks(16'hFFFF);
        send_char("Q", 1'b0);
        send_char("0", 1'b0);
        send_char("a", 1'b1);
        send_char("z", 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h80, 1'b0);
        send_char("9", 1'b1);
    endtask

    // Zero unit length: all durations zero, shape unchanged
    task automatic test_zero_unit();
        set_unit_ticks(16'h0000);
        send_char("J", 1'b0);
        send_char("9", 1'b1);
        send_char(ASC_SPACE, 1'b0);
        send_char("@", 1'b1);
    endtask

    // Shortest unit; characters just outside the letter and digit ranges
    task automatic test_single_tick_unit();
        set_unit_ticks(16'h0001);
        send_char(8'h60, 1'b0);
        send_char("{", 1'b1);
        send_char("[", 1'b0);
        send_char("/", 1'b1);
        send_char(":", 1'b0);
        send_char("Z", 1'b0);
        send_char("A", 1'b1);
        send_char("5", 1'b1);
    endtask

    // Random messages under several unit lengths, one phase without idling
    task automatic test_random_messages();
        set_unit_ticks(16'($urandom_range(65535, 1)));
        send_messages(50);
        set_unit_ticks(16'hFFFF);
        no_idle = 1'b1;
        send_messages(50);
        no_idle = 1'b0;
        set_unit_ticks(16'($urandom_range(40, 1)));
        send_messages(50);
        set_unit_ticks(16'd500);
        send_messages(50);
    endtask

    // Randomly stall the interval channel
    always @(negedge i_clk) begin
        interval_ch.ready <= !take_break();
    end

    // Compare each interval transaction with the oldest expectation
    always @(posedge i_clk) begin : check_interval
        t_result want;
        t_result got;
        if (i_rst_n && interval_ch.valid === 1'b1 && interval_ch.ready === 1'b1) begin
            got.led_on         = interval_ch.led_on;
            got.duration_ticks = interval_ch.duration_ticks;
            got.last_of_char   = interval_ch.last_of_char;
            got.message_done   = interval_ch.message_done;
            if (intervals_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected interval on=%0b dur=%0d last=%0b done=%0b",
                             $realtime, got.led_on, got.duration_ticks,
                             got.last_of_char, got.message_done);
            end else begin
                want = intervals_due.pop_front();
                intervals_checked++;
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $write("%0t: interval mismatch: expected on=%0b dur=%0d last=%0b done=%0b",
                               $realtime, want.led_on, want.duration_ticks,
                               want.last_of_char, want.message_done);
                        $display(", got on=%0b dur=%0d last=%0b done=%0b",
                                 got.led_on, got.duration_ticks,
                                 got.last_of_char, got.message_done);
                    end
                end
            end
        end
    end

    // Abort when outstanding work stops moving
    always @(posedge i_clk) begin
        if ((char_ch.valid === 1'b1 && char_ch.ready === 1'b1) ||
            (interval_ch.valid === 1'b1 && interval_ch.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (intervals_due.size() != 0 || char_ch.valid === 1'b1) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("** morse_led_keyer_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        char_ch.valid          = 1'b0;
        char_ch.char_code      = '0;
        char_ch.end_of_message = 1'b0;
        interval_ch.ready      = 1'b0;
        unit_len               = 16'd500;
        fail_count             = 0;
        chars_sent             = 0;
        intervals_checked      = 0;
        settings_used          = 1;
        no_idle                = 1'b0;
        stall_cycles           = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_length();
        test_long_unit();
        test_zero_unit();
        test_single_tick_unit();
        test_random_messages();

        // Drain, then watch for stray intervals
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Keyed %0d characters into %0d checked intervals over %0d unit lengths",
                 chars_sent, intervals_checked, settings_used);
        $display("(unit lengths include 0, 1, 500 and 65535; %0d mismatches)", fail_count);
        if (fail_count == 0) begin
            $display("** morse_led_keyer_unit: PASSED **");
        end else begin
            $display("** morse_led_keyer_unit: FAILED **");
        end
        $finish;
    end

endmodule
